/* sv/isc_pkg.sv */
package isc_pkg;

  localparam int ID_W    = 12;
  localparam int EID_W   = 20;
  localparam int LOCAL_W = 10;
  localparam int ROW_W   = 21;
  localparam int EPOCH_W = 8;

  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef enum logic [1:0] {
    OP_START_JOB = 2'd0,
    OP_LOAD      = 2'd1,
    OP_EDGE      = 2'd2,
    OP_END_ROW   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_EDGE     = 2'd0,
    KIND_ROW_PTR  = 2'd1,
    KIND_OVERFLOW = 2'd2
  } kind_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [LOCAL_W-1:0] local_idx;
  } map_entry_t;

endpackage

/* sv/isc_map_ram.sv */
module isc_map_ram #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  isc_pkg::map_entry_t wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output isc_pkg::map_entry_t rdata
);

  isc_pkg::map_entry_t mem [DEPTH];
  isc_pkg::map_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/induced_subgraph_csr_filter_core.sv */
// Induced subgraph extraction over a streamed CSR graph.
// Input channel: an item (in_op, in_node_id, in_neighbor_id, in_edge_id) is
// taken at a rising edge with start high and busy low. A start-job item opens a
// new job, load items map selected node ids to local indexes, edge items are
// checked against the map and end-of-row items report the running kept count.
// Result channel: out_valid marks one cycle carrying out_kind, out_local_col,
// out_kept_edge_id and out_row_offset. The receiver cannot stall; every result
// is taken in the cycle it is shown.
// An item is held in the stage-1 registers while the map is read, and its result
// is shown from the output registers, to be taken at the end of that cycle.
// Throughput: one item per cycle while busy is low. The map is a single
// memory with a registered read port, read at accept and written back from
// stage 1; a write-to-read bypass covers back-to-back items on the same node id.
// Map entries carry an 8-bit job tag, so a start-job item need not wipe the map.
// Every 255th start job and every reset run a clearing pass over the map's
// min(GRAPH_NODES, 4096) entries, one entry per cycle, with busy held high.
// Reset is synchronous, active low, and starts that clearing pass.
module induced_subgraph_csr_filter_core #(
  parameter int GRAPH_NODES = 4096,
  parameter int SUB_NODES   = 1024,
  parameter int MAX_EDGES   = 1048576
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [1:0]                  in_op,
  input  logic [isc_pkg::ID_W-1:0]    in_node_id,
  input  logic [isc_pkg::ID_W-1:0]    in_neighbor_id,
  input  logic [isc_pkg::EID_W-1:0]   in_edge_id,
  output logic                        busy,
  output logic                        out_valid,
  output logic [1:0]                  out_kind,
  output logic [isc_pkg::LOCAL_W-1:0] out_local_col,
  output logic [isc_pkg::EID_W-1:0]   out_kept_edge_id,
  output logic [isc_pkg::ROW_W-1:0]   out_row_offset
);

  localparam int ID_SPAN   = 1 << isc_pkg::ID_W;
  localparam int MAP_DEPTH = (GRAPH_NODES < ID_SPAN) ? GRAPH_NODES : ID_SPAN;
  localparam int ADDR_W    = $clog2(MAP_DEPTH);
  localparam int NL_W      = $clog2(SUB_NODES + 1);
  localparam int KC_W      = $clog2(MAX_EDGES + 1);

  isc_pkg::state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]            clr_addr_r, clr_addr_nxt;
  logic [isc_pkg::EPOCH_W-1:0]  epoch_r, epoch_nxt;
  logic [NL_W-1:0]              next_local_r, next_local_nxt;
  logic [KC_W-1:0]              kept_r, kept_nxt;

  logic                         s1_valid_r;
  isc_pkg::op_t                 s1_op_r;
  logic [ADDR_W-1:0]            s1_addr_r;
  logic                         s1_range_r;
  logic [isc_pkg::EID_W-1:0]    s1_eid_r;
  logic                         fwd_hit_r;
  isc_pkg::map_entry_t          fwd_data_r;

  logic                         res_valid;
  isc_pkg::kind_t               res_kind;
  logic [isc_pkg::LOCAL_W-1:0]  res_col;
  logic [isc_pkg::EID_W-1:0]    res_eid;
  logic [isc_pkg::ROW_W-1:0]    res_row;

  logic                         out_valid_r;
  logic [1:0]                   out_kind_r;
  logic [isc_pkg::LOCAL_W-1:0]  out_local_col_r;
  logic [isc_pkg::EID_W-1:0]    out_kept_edge_id_r;
  logic [isc_pkg::ROW_W-1:0]    out_row_offset_r;

  logic                         accept;
  isc_pkg::op_t                 in_op_e;
  logic [isc_pkg::ID_W-1:0]     in_sel_id;
  logic                         in_range;
  logic [ADDR_W-1:0]            in_addr;

  logic                         s1_we;
  isc_pkg::map_entry_t          s1_wdata;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  isc_pkg::map_entry_t          mem_wdata;
  isc_pkg::map_entry_t          rd_data;
  isc_pkg::map_entry_t          entry;
  logic                         mapped;

  assign busy = (state_r == isc_pkg::ST_CLEAR) ||
                (s1_valid_r && (s1_op_r == isc_pkg::OP_START_JOB) &&
                 (epoch_r == isc_pkg::EPOCH_LAST));
  assign accept = start && !busy;

  assign in_op_e   = isc_pkg::op_t'(in_op);
  assign in_sel_id = (in_op_e == isc_pkg::OP_LOAD) ? in_node_id : in_neighbor_id;
  assign in_range  = 32'(in_sel_id) < 32'(MAP_DEPTH);
  assign in_addr   = ADDR_W'(in_sel_id);

  assign entry  = fwd_hit_r ? fwd_data_r : rd_data;
  assign mapped = s1_range_r && (entry.epoch == epoch_r);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    epoch_nxt      = epoch_r;
    next_local_nxt = next_local_r;
    kept_nxt       = kept_r;
    s1_we          = 1'b0;
    s1_wdata       = '{epoch: epoch_r, local_idx: isc_pkg::LOCAL_W'(next_local_r)};
    res_valid      = 1'b0;
    res_kind       = isc_pkg::KIND_EDGE;
    res_col        = '0;
    res_eid        = '0;
    res_row        = '0;

    unique case (state_r)
      isc_pkg::ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        if (clr_addr_r == ADDR_W'(MAP_DEPTH - 1)) begin
          clr_addr_nxt = '0;
          state_nxt    = isc_pkg::ST_RUN;
        end
      end
      isc_pkg::ST_RUN: begin
        if (s1_valid_r) begin
          unique case (s1_op_r)
            isc_pkg::OP_START_JOB: begin
              next_local_nxt = '0;
              kept_nxt       = '0;
              if (epoch_r == isc_pkg::EPOCH_LAST) begin
                epoch_nxt = isc_pkg::EPOCH_FIRST;
                state_nxt = isc_pkg::ST_CLEAR;
              end else begin
                epoch_nxt = epoch_r + isc_pkg::EPOCH_W'(1);
              end
            end
            isc_pkg::OP_LOAD: begin
              if (next_local_r >= NL_W'(SUB_NODES)) begin
                res_valid = 1'b1;
                res_kind  = isc_pkg::KIND_OVERFLOW;
              end else begin
                s1_we          = s1_range_r && !mapped;
                next_local_nxt = next_local_r + NL_W'(1);
              end
            end
            isc_pkg::OP_EDGE: begin
              if (mapped) begin
                if (kept_r < KC_W'(MAX_EDGES)) begin
                  kept_nxt = kept_r + KC_W'(1);
                end
                res_valid = 1'b1;
                res_kind  = isc_pkg::KIND_EDGE;
                res_col   = entry.local_idx;
                res_eid   = s1_eid_r;
                res_row   = isc_pkg::ROW_W'(kept_nxt);
              end
            end
            isc_pkg::OP_END_ROW: begin
              res_valid = 1'b1;
              res_kind  = isc_pkg::KIND_ROW_PTR;
              res_row   = isc_pkg::ROW_W'(kept_r);
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = isc_pkg::ST_CLEAR;
      end
    endcase
  end

  // Clearing pass owns the write port; no item is in flight then.
  always_comb begin
    if (state_r == isc_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '{epoch: isc_pkg::EPOCH_NONE, local_idx: '0};
    end else begin
      mem_we    = s1_we;
      mem_waddr = s1_addr_r;
      mem_wdata = s1_wdata;
    end
  end

  isc_map_ram #(
    .DEPTH  (MAP_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (in_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= isc_pkg::ST_CLEAR;
      clr_addr_r   <= '0;
      epoch_r      <= isc_pkg::EPOCH_FIRST;
      next_local_r <= '0;
      kept_r       <= '0;
      s1_valid_r   <= 1'b0;
      fwd_hit_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      epoch_r      <= epoch_nxt;
      next_local_r <= next_local_nxt;
      kept_r       <= kept_nxt;
      s1_valid_r   <= accept;
      // bypass the write that lands on the same edge as this read
      fwd_hit_r    <= accept && s1_we && (s1_addr_r == in_addr);
      out_valid_r  <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= in_op_e;
      s1_addr_r  <= in_addr;
      s1_range_r <= in_range;
      s1_eid_r   <= in_edge_id;
    end
    fwd_data_r         <= s1_wdata;
    out_kind_r         <= res_kind;
    out_local_col_r    <= res_col;
    out_kept_edge_id_r <= res_eid;
    out_row_offset_r   <= res_row;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_local_col    = out_local_col_r;
  assign out_kept_edge_id = out_kept_edge_id_r;
  assign out_row_offset   = out_row_offset_r;

endmodule

/* sv/isc_checker.sv */
module isc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic [1:0]                  in_op,
  input logic                        busy,
  input logic                        out_valid,
  input logic [1:0]                  out_kind,
  input logic [isc_pkg::LOCAL_W-1:0] out_local_col,
  input logic [isc_pkg::EID_W-1:0]   out_kept_edge_id,
  input logic [isc_pkg::ROW_W-1:0]   out_row_offset
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("busy low right after reset");

  a_result_follows_transaction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted transaction two cycles earlier");

  a_overflow_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == isc_pkg::KIND_OVERFLOW)) |->
      (out_local_col == '0) && (out_kept_edge_id == '0) && (out_row_offset == '0))
    else $error("overflow result with nonzero fields");

  a_row_ptr_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == isc_pkg::KIND_ROW_PTR)) |->
      (out_local_col == '0) && (out_kept_edge_id == '0))
    else $error("row pointer result with nonzero edge fields");

  a_fresh_job_row_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == isc_pkg::OP_START_JOB)) ##1
    (start && !busy && (in_op == isc_pkg::OP_END_ROW)) |->
      ##2 (out_valid && (out_kind == isc_pkg::KIND_ROW_PTR) && (out_row_offset == '0)))
    else $error("row pointer after a new job is not zero");

endmodule

bind induced_subgraph_csr_filter_core isc_checker u_isc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .in_op            (in_op),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_kind         (out_kind),
  .out_local_col    (out_local_col),
  .out_kept_edge_id (out_kept_edge_id),
  .out_row_offset   (out_row_offset)
);
